### rtl/twi_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// twi_pkg
// Types and constants shared by the tween interpolator files.
// ----------------------------------------------------------------------------
package twi_pkg;

  localparam int FRACTION_BITS = 16;
  localparam int FRAC_W        = FRACTION_BITS + 1;
  localparam int ELAPSED_W     = 31;
  localparam int VALUE_W       = 32;
  localparam int DUR_W         = 20;
  localparam int MODE_W        = 2;
  localparam int DIFF_W        = VALUE_W + 1;
  localparam int CFG_IDX_W     = 1;
  localparam int CFG_DATA_W    = DUR_W;

  // difference is split at FRACTION_BITS for the two partial products
  localparam int LO_W  = FRACTION_BITS;
  localparam int HI_W  = DIFF_W - FRACTION_BITS;
  localparam int PLO_W = FRAC_W + LO_W;
  localparam int PHI_W = FRAC_W + 1 + HI_W;

  localparam logic [FRAC_W-1:0] FRAC_ONE = {1'b1, {FRACTION_BITS{1'b0}}};

  localparam logic [CFG_IDX_W-1:0] REG_DURATION_MS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ANIM_MODE   = 1'b1;

  typedef enum logic [MODE_W-1:0] {
    MODE_CLAMP    = 2'd0,
    MODE_REPEAT   = 2'd1,
    MODE_PINGPONG = 2'd2
  } anim_mode_t;

  typedef struct packed {
    logic [ELAPSED_W-1:0]      elapsed_ms;
    logic signed [VALUE_W-1:0] start_value;
    logic signed [VALUE_W-1:0] end_value;
  } sample_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic [FRAC_W-1:0]         fraction;
    logic                      complete;
  } result_t;

endpackage
`default_nettype wire

### rtl/twi_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// twi_sample_if / twi_result_if
// Valid/ready channels for input samples and interpolated results.
// ----------------------------------------------------------------------------
interface twi_sample_if;
  logic                               valid;
  logic                               ready;
  logic [twi_pkg::ELAPSED_W-1:0]      elapsed_ms;
  logic signed [twi_pkg::VALUE_W-1:0] start_value;
  logic signed [twi_pkg::VALUE_W-1:0] end_value;

  modport source (output valid, elapsed_ms, start_value, end_value, input ready);
  modport sink   (input valid, elapsed_ms, start_value, end_value, output ready);
endinterface

interface twi_result_if;
  logic                               valid;
  logic                               ready;
  logic signed [twi_pkg::VALUE_W-1:0] value;
  logic [twi_pkg::FRAC_W-1:0]         fraction;
  logic                               complete;

  modport source (output valid, value, fraction, complete, input ready);
  modport sink   (input valid, value, fraction, complete, output ready);
endinterface
`default_nettype wire

### rtl/twi_pipe.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// twi_pipe
// Pipelined datapath: period fold by restoring division (one quotient bit a
// stage), fraction division (one bit a stage), split multiply and add.
// ----------------------------------------------------------------------------
module twi_pipe (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           en,
  input  wire logic                           in_valid,
  input  wire twi_pkg::sample_t               in_word,
  input  wire logic [twi_pkg::DUR_W-1:0]      duration,
  input  wire logic [twi_pkg::MODE_W-1:0]     anim_mode,
  output logic                                tail_valid,
  output twi_pkg::result_t                    tail
);

  typedef struct packed {
    logic [twi_pkg::ELAPSED_W-1:0]      elapsed;
    logic [twi_pkg::DUR_W-1:0]          rem;
    logic                               qbit;
    logic signed [twi_pkg::VALUE_W-1:0] start;
    logic signed [twi_pkg::DIFF_W-1:0]  diff;
    logic                               dz;
    logic                               ge;
  } mod_t;

  typedef struct packed {
    logic [twi_pkg::DUR_W-1:0]          rem;
    logic [twi_pkg::FRACTION_BITS-1:0]  q;
    logic                               sat;
    logic signed [twi_pkg::VALUE_W-1:0] start;
    logic signed [twi_pkg::DIFF_W-1:0]  diff;
  } frac_t;

  logic mv [0:twi_pkg::ELAPSED_W];
  mod_t ms [0:twi_pkg::ELAPSED_W];
  logic fv [0:twi_pkg::FRACTION_BITS];
  frac_t fs [0:twi_pkg::FRACTION_BITS];

  // capture stage
  always_ff @(posedge clk) begin
    if (rst) begin
      mv[0] <= 1'b0;
    end else if (en) begin
      mv[0] <= in_valid;
    end
    if (en) begin
      ms[0].elapsed <= in_word.elapsed_ms;
      ms[0].rem     <= '0;
      ms[0].qbit    <= 1'b0;
      ms[0].start   <= in_word.start_value;
      ms[0].diff    <= twi_pkg::DIFF_W'(in_word.end_value)
                     - twi_pkg::DIFF_W'(in_word.start_value);
      ms[0].dz      <= (duration == '0);
      ms[0].ge      <= (in_word.elapsed_ms >= twi_pkg::ELAPSED_W'(duration));
    end
  end

  // elapsed / duration, MSB first; keeps remainder and last quotient bit
  for (genvar k = 1; k <= twi_pkg::ELAPSED_W; k++) begin : g_mod
    logic [twi_pkg::DUR_W:0] rem_sh;
    logic                    take;
    mod_t                    ms_next;

    always_comb begin
      rem_sh       = {ms[k-1].rem, ms[k-1].elapsed[twi_pkg::ELAPSED_W-k]};
      take         = (rem_sh >= {1'b0, duration});
      ms_next      = ms[k-1];
      ms_next.rem  = take ? twi_pkg::DUR_W'(rem_sh - {1'b0, duration})
                          : rem_sh[twi_pkg::DUR_W-1:0];
      ms_next.qbit = take;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        mv[k] <= 1'b0;
      end else if (en) begin
        mv[k] <= mv[k-1];
      end
      if (en) begin
        ms[k] <= ms_next;
      end
    end
  end

  // fold the period position into t, flag saturation
  logic                      mirror;
  logic                      pingpong;
  logic                      repeating;
  logic                      t_sat;
  logic [twi_pkg::DUR_W-1:0] t_val;

  always_comb begin
    pingpong  = (anim_mode == twi_pkg::MODE_PINGPONG);
    repeating = (anim_mode == twi_pkg::MODE_REPEAT);
    mirror    = pingpong && ms[twi_pkg::ELAPSED_W].qbit;
    // odd period with zero remainder lands exactly on the end
    t_sat     = ms[twi_pkg::ELAPSED_W].dz
             || (!pingpong && !repeating && ms[twi_pkg::ELAPSED_W].ge)
             || (mirror && (ms[twi_pkg::ELAPSED_W].rem == '0));
    t_val     = mirror ? duration - ms[twi_pkg::ELAPSED_W].rem
                       : ms[twi_pkg::ELAPSED_W].rem;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fv[0] <= 1'b0;
    end else if (en) begin
      fv[0] <= mv[twi_pkg::ELAPSED_W];
    end
    if (en) begin
      fs[0].rem   <= t_val;
      fs[0].q     <= '0;
      fs[0].sat   <= t_sat;
      fs[0].start <= ms[twi_pkg::ELAPSED_W].start;
      fs[0].diff  <= ms[twi_pkg::ELAPSED_W].diff;
    end
  end

  // (t << FRACTION_BITS) / duration with t < duration
  for (genvar j = 1; j <= twi_pkg::FRACTION_BITS; j++) begin : g_frac
    logic [twi_pkg::DUR_W:0] rem_sh;
    logic                    take;
    frac_t                   fs_next;

    always_comb begin
      rem_sh      = {fs[j-1].rem, 1'b0};
      take        = (rem_sh >= {1'b0, duration});
      fs_next     = fs[j-1];
      fs_next.rem = take ? twi_pkg::DUR_W'(rem_sh - {1'b0, duration})
                         : rem_sh[twi_pkg::DUR_W-1:0];
      fs_next.q   = {fs[j-1].q[twi_pkg::FRACTION_BITS-2:0], take};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        fv[j] <= 1'b0;
      end else if (en) begin
        fv[j] <= fv[j-1];
      end
      if (en) begin
        fs[j] <= fs_next;
      end
    end
  end

  // partial products of fraction * diff
  logic [twi_pkg::FRAC_W-1:0]         frac_sel;
  logic                               m1v;
  logic [twi_pkg::PLO_W-1:0]          p_lo;
  logic signed [twi_pkg::PHI_W-1:0]   p_hi;
  logic signed [twi_pkg::VALUE_W-1:0] m1_start;
  logic [twi_pkg::FRAC_W-1:0]         m1_frac;

  assign frac_sel = fs[twi_pkg::FRACTION_BITS].sat ? twi_pkg::FRAC_ONE
                  : {1'b0, fs[twi_pkg::FRACTION_BITS].q};

  always_ff @(posedge clk) begin
    if (rst) begin
      m1v <= 1'b0;
    end else if (en) begin
      m1v <= fv[twi_pkg::FRACTION_BITS];
    end
    if (en) begin
      p_lo     <= frac_sel * fs[twi_pkg::FRACTION_BITS].diff[twi_pkg::LO_W-1:0];
      p_hi     <= $signed({1'b0, frac_sel})
                * $signed(fs[twi_pkg::FRACTION_BITS].diff[twi_pkg::DIFF_W-1:twi_pkg::LO_W]);
      m1_start <= fs[twi_pkg::FRACTION_BITS].start;
      m1_frac  <= frac_sel;
    end
  end

  // floor shift: p_lo is non-negative, so its low bits only drop
  logic                               m2v;
  logic signed [twi_pkg::PHI_W-1:0]   step;
  logic signed [twi_pkg::VALUE_W-1:0] m2_start;
  logic [twi_pkg::FRAC_W-1:0]         m2_frac;

  always_ff @(posedge clk) begin
    if (rst) begin
      m2v <= 1'b0;
    end else if (en) begin
      m2v <= m1v;
    end
    if (en) begin
      step     <= p_hi + $signed(twi_pkg::PHI_W'(p_lo >> twi_pkg::FRACTION_BITS));
      m2_start <= m1_start;
      m2_frac  <= m1_frac;
    end
  end

  // result lies between start and end, so the truncation is exact
  always_ff @(posedge clk) begin
    if (rst) begin
      tail_valid <= 1'b0;
    end else if (en) begin
      tail_valid <= m2v;
    end
    if (en) begin
      tail.value    <= twi_pkg::VALUE_W'(twi_pkg::PHI_W'(m2_start) + step);
      tail.fraction <= m2_frac;
      tail.complete <= (m2_frac == twi_pkg::FRAC_ONE);
    end
  end

endmodule
`default_nettype wire

### rtl/tween_interpolator_repeat_pingpong_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tween_interpolator_repeat_pingpong_top
// Linear tween of one Q16.16 channel with clamp, repeat and ping-pong timing.
// ----------------------------------------------------------------------------
//   channel   dir  word                                    handshake
//   sample    in   elapsed_ms, start_value, end_value      valid/ready
//   result    out  value, fraction, complete               valid/ready
//   cfg_*     in   cfg_index, cfg_data                     cfg_we, no stall
//
// One word accepted per cycle while the skid register is empty. In order:
// 31 one-bit restoring stages fold the elapsed time, FRACTION_BITS stages
// divide out the fraction, three stages multiply and add.
// Reset clears the valid bits and sets duration_ms and anim_mode to 0.
// A stalled result parks one word in a skid register; sample.ready then drops
// and the whole pipeline holds until the skid register drains.
// ----------------------------------------------------------------------------
module tween_interpolator_repeat_pingpong_top (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [twi_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [twi_pkg::CFG_DATA_W-1:0]   cfg_data,
  twi_sample_if.sink                            sample,
  twi_result_if.source                          result
);

  logic [twi_pkg::DUR_W-1:0]  duration_ms;
  logic [twi_pkg::MODE_W-1:0] anim_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      duration_ms <= '0;
      anim_mode   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        twi_pkg::REG_DURATION_MS: duration_ms <= cfg_data;
        twi_pkg::REG_ANIM_MODE:   anim_mode   <= cfg_data[twi_pkg::MODE_W-1:0];
        default: ;
      endcase
    end
  end

  logic              skid_valid;
  logic              out_valid;
  logic              pipe_en;
  logic              tail_valid;
  twi_pkg::sample_t  in_word;
  twi_pkg::result_t  tail;
  twi_pkg::result_t  out_word;
  twi_pkg::result_t  skid_word;

  assign pipe_en      = !skid_valid;
  assign sample.ready = !skid_valid;

  always_comb begin
    in_word.elapsed_ms  = sample.elapsed_ms;
    in_word.start_value = sample.start_value;
    in_word.end_value   = sample.end_value;
  end

  twi_pipe u_pipe (
    .clk        (clk),
    .rst        (rst),
    .en         (pipe_en),
    .in_valid   (sample.valid),
    .in_word    (in_word),
    .duration   (duration_ms),
    .anim_mode  (anim_mode),
    .tail_valid (tail_valid),
    .tail       (tail)
  );

  // output register plus skid register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || result.ready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid  <= tail_valid;
      end
    end else if (tail_valid && !skid_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || result.ready) begin
      out_word <= skid_valid ? skid_word : tail;
    end else if (!skid_valid) begin
      skid_word <= tail;
    end
  end

  assign result.valid    = out_valid;
  assign result.value    = out_word.value;
  assign result.fraction = out_word.fraction;
  assign result.complete = out_word.complete;

  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid word held with empty output register");

  a_skid_drains: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && result.ready) |=> (!skid_valid && out_valid))
    else $error("skid word not moved on output take");

  a_frac_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_word.fraction <= twi_pkg::FRAC_ONE))
    else $error("fraction above 1.0");

  a_complete_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_word.complete == (out_word.fraction == twi_pkg::FRAC_ONE)))
    else $error("complete flag disagrees with fraction");

endmodule
`default_nettype wire
